// ----- hw/rtl/ptob_pkg.sv -----
// ----------------------------------------------------------------------------
// ptob_pkg
// Types, constants and the rank compare shared by the order book insert block.
// ----------------------------------------------------------------------------
`default_nettype none

package ptob_pkg;

	localparam int BOOK_DEPTH_DEF = 64;

	typedef struct packed {
		logic        side;
		logic [31:0] price_ticks;
		logic [31:0] order_seq;
		logic [23:0] order_qty;
		logic [23:0] filled_qty;
	} order_t;

	typedef struct packed {
		logic        accepted;
		logic [5:0]  insert_pos;
		logic [6:0]  side_count;
		logic [31:0] top_price;
		logic [31:0] top_seq;
	} result_t;

	typedef struct packed {
		logic [31:0] price;
		logic [31:0] seq;
		logic [23:0] qty;
		logic [23:0] fill;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_PLACE,
		ST_RESP
	} state_t;

	// resting entry ranks behind the new order
	function automatic logic ranks_behind(input logic is_ask, input logic [31:0] rp,
		input logic [31:0] rs, input logic [31:0] np, input logic [31:0] ns);
		logic r;
		if (rp != np) begin
			r = is_ask ? (rp > np) : (rp < np);
		end else begin
			r = (rs > ns);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/price_time_order_book_insert.sv -----
// ----------------------------------------------------------------------------
// price_time_order_book_insert
// Inserts one order at a time into a bounded price-time sorted book per side.
// ----------------------------------------------------------------------------
// Orders arrive on the order channel (valid/ready), results leave on the
// result channel (valid/ready), one result item per order item.
// Bids sort by descending price, asks by ascending price, ties by lower
// sequence first; a new order goes after equal entries.
// Both sides live in one RAM (address = side, rank). A single compare unit
// walks the side from its worst entry upward, one entry per cycle, moving
// each entry that ranks behind the new order one rank down, then writes the
// new order into the gap.
// A side with entries goes through the RAM read-compare-write loop before
// the result is registered; an empty side or a reject of a full side skips
// the scan.
// One order is in flight at a time: order_ready is low from accept until
// the result is taken and rises the cycle after, so the next order is taken
// in the cycle after the result at the earliest; a stalled receiver holds the block.
// Reset empties both sides (counts cleared); RAM contents need no clearing
// since only ranks below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module price_time_order_book_insert
	import ptob_pkg::*;
#(
	parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    order_valid,
	output logic         order_ready,
	input  wire order_t  order,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	localparam int IW = $clog2(BOOK_DEPTH);
	localparam int CW = $clog2(BOOK_DEPTH + 1);
	localparam int AW = IW + 1;
	localparam int RAM_DEPTH = 2 * (1 << IW);

	state_t          state_q, state_d;
	order_t          item_q;
	logic [IW-1:0]   idx_q, idx_d;
	logic [CW-1:0]   count_q [2];
	logic [31:0]     top_price_q [2];
	logic [31:0]     top_seq_q [2];
	result_t         result_q;
	logic            result_valid_q;

	logic            we, re;
	logic [AW-1:0]   waddr, raddr;
	entry_t          wdata, rdata;
	entry_t          new_entry;
	logic            behind;
	logic [CW-1:0]   cnt;
	logic            done, done_acc;
	logic [IW-1:0]   done_pos;

	ptob_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign new_entry = '{price: item_q.price_ticks, seq: item_q.order_seq,
		qty: item_q.order_qty, fill: item_q.filled_qty};
	assign cnt = count_q[item_q.side];
	assign behind = ranks_behind(item_q.side, rdata.price, rdata.seq,
		item_q.price_ticks, item_q.order_seq);

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		we       = 1'b0;
		re       = 1'b0;
		waddr    = {item_q.side, idx_q + IW'(1)};
		raddr    = {item_q.side, idx_q - IW'(1)};
		wdata    = new_entry;
		done     = 1'b0;
		done_acc = 1'b0;
		done_pos = '0;
		case (state_q)
			ST_IDLE: begin
				if (order_valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (cnt == CW'(BOOK_DEPTH)) begin
					done = 1'b1;
				end else if (cnt == '0) begin
					we       = 1'b1;
					waddr    = {item_q.side, {IW{1'b0}}};
					done     = 1'b1;
					done_acc = 1'b1;
				end else begin
					re      = 1'b1;
					idx_d   = IW'(cnt - CW'(1));
					raddr   = {item_q.side, idx_d};
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				we = 1'b1;
				if (behind) begin
					wdata = rdata;
					if (idx_q == '0) begin
						state_d = ST_PLACE;
					end else begin
						re    = 1'b1;
						idx_d = idx_q - IW'(1);
					end
				end else begin
					done     = 1'b1;
					done_acc = 1'b1;
					done_pos = idx_q + IW'(1);
				end
			end
			ST_PLACE: begin
				we       = 1'b1;
				waddr    = {item_q.side, {IW{1'b0}}};
				done     = 1'b1;
				done_acc = 1'b1;
			end
			ST_RESP: begin
				if (result_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (done) begin
			state_d = ST_RESP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q[0]     <= '0;
			count_q[1]     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done) begin
				result_valid_q <= 1'b1;
				if (done_acc) begin
					count_q[item_q.side] <= cnt + CW'(1);
				end
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (state_q == ST_IDLE && order_valid) begin
			item_q <= order;
		end
		if (done) begin
			result_q.accepted   <= done_acc;
			result_q.insert_pos <= 6'(done_pos);
			result_q.side_count <= done_acc ? 7'(cnt + CW'(1)) : 7'(cnt);
			if (done_acc && done_pos == '0) begin
				top_price_q[item_q.side] <= item_q.price_ticks;
				top_seq_q[item_q.side]   <= item_q.order_seq;
				result_q.top_price       <= item_q.price_ticks;
				result_q.top_seq         <= item_q.order_seq;
			end else begin
				result_q.top_price <= top_price_q[item_q.side];
				result_q.top_seq   <= top_seq_q[item_q.side];
			end
		end
	end

	assign order_ready  = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !order_ready)
		else $error("order taken while a result item waits");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q[0] <= CW'(BOOK_DEPTH)) && (count_q[1] <= CW'(BOOK_DEPTH)))
		else $error("side count beyond book depth");

	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.accepted) |-> (result.side_count == 7'(BOOK_DEPTH)))
		else $error("reject reported on a side that is not full");

	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_ready) |=> order_ready)
		else $error("block not ready after result item taken");

endmodule

`default_nettype wire

// ----- hw/rtl/ptob_ram.sv -----
// ----------------------------------------------------------------------------
// ptob_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptob_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
